@@ hdl/dsl_char_tokenizer_defines.svh @@
// ----------------------------------------------------------------------------
// dsl_char_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL files.
// ----------------------------------------------------------------------------
`ifndef DSL_CHAR_TOKENIZER_DEFINES_SVH
`define DSL_CHAR_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define DCT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed (same cycle)");
// Next-cycle implication.
`define DCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed (next cycle)");
`else
`define DCT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DCT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hdl/dct_pkg.sv @@
// ----------------------------------------------------------------------------
// dct_pkg
// Types, codes and character classes shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package dct_pkg;

   localparam int POS_WIDTH = 16;
   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

   localparam int MAX_RESULTS = 3;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   // token kinds
   localparam logic [4:0] KIND_END    = 5'd0;
   localparam logic [4:0] KIND_IDENT  = 5'd1;
   localparam logic [4:0] KIND_NUMBER = 5'd2;
   localparam logic [4:0] KIND_LBRACE = 5'd3;
   localparam logic [4:0] KIND_RBRACE = 5'd4;
   localparam logic [4:0] KIND_LPAREN = 5'd5;
   localparam logic [4:0] KIND_RPAREN = 5'd6;
   localparam logic [4:0] KIND_LBRACK = 5'd7;
   localparam logic [4:0] KIND_RBRACK = 5'd8;
   localparam logic [4:0] KIND_COLON  = 5'd9;
   localparam logic [4:0] KIND_SEMI   = 5'd10;
   localparam logic [4:0] KIND_COMMA  = 5'd11;
   localparam logic [4:0] KIND_ASSIGN = 5'd12;
   localparam logic [4:0] KIND_PLUS   = 5'd13;
   localparam logic [4:0] KIND_MINUS  = 5'd14;
   localparam logic [4:0] KIND_STAR   = 5'd15;
   localparam logic [4:0] KIND_SLASH  = 5'd16;
   localparam logic [4:0] KIND_CARET  = 5'd17;
   localparam logic [4:0] KIND_ERROR  = 5'd18;

   // characters with a role of their own
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_LOWER_E = 8'h65;
   localparam logic [7:0] CHAR_UPPER_E = 8'h45;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_CARET   = 8'h5E;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_IDENT  = 3'd1,
      MODE_NUMBER = 3'd2,
      MODE_SLASH  = 3'd3,
      MODE_DOT    = 3'd4,
      MODE_LINE   = 3'd5,
      MODE_BLOCK  = 3'd6
   } lex_mode_type;

   typedef struct packed {
      logic [4:0]           kind;
      logic                 malformed;
      logic [POS_WIDTH-1:0] line;
      logic [POS_WIDTH-1:0] column;
      logic [POS_WIDTH-1:0] length;
      logic                 last;
   } token_type;

   // tokens produced by one accepted request, oldest in slot 0
   typedef struct packed {
      logic [1:0]                     count;
      token_type [MAX_RESULTS-1:0]    tok;
   } push_type;

   function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
      return (v == POS_MAX) ? v : v + POS_WIDTH'(1);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic is_ident_char(input logic [7:0] b);
      return is_alpha(b) || is_digit(b) || b == CHAR_UNDER;
   endfunction

   function automatic logic [4:0] punct_kind(input logic [7:0] b);
      logic [4:0] k;
      unique case (b)
         8'h7B:      k = KIND_LBRACE;
         8'h7D:      k = KIND_RBRACE;
         8'h28:      k = KIND_LPAREN;
         8'h29:      k = KIND_RPAREN;
         8'h5B:      k = KIND_LBRACK;
         8'h5D:      k = KIND_RBRACK;
         8'h3A:      k = KIND_COLON;
         8'h3B:      k = KIND_SEMI;
         8'h2C:      k = KIND_COMMA;
         8'h3D:      k = KIND_ASSIGN;
         CHAR_PLUS:  k = KIND_PLUS;
         CHAR_MINUS: k = KIND_MINUS;
         CHAR_STAR:  k = KIND_STAR;
         CHAR_SLASH: k = KIND_SLASH;
         CHAR_CARET: k = KIND_CARET;
         default:    k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic token_type mk_token(input logic [4:0] kind, input logic bad,
                                          input logic [POS_WIDTH-1:0] line,
                                          input logic [POS_WIDTH-1:0] column,
                                          input logic [POS_WIDTH-1:0] length);
      token_type t;
      t.kind      = kind;
      t.malformed = bad;
      t.line      = line;
      t.column    = column;
      t.length    = length;
      t.last      = 1'b0;
      return t;
   endfunction

endpackage

@@ hdl/dct_lex_core.sv @@
// ----------------------------------------------------------------------------
// dct_lex_core
// Lexer state and per-byte next-state logic; yields up to three tokens.
// ----------------------------------------------------------------------------
`include "dsl_char_tokenizer_defines.svh"

module dct_lex_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  logic [7:0]        char_code,
   input  logic              end_of_source,
   output dct_pkg::push_type push
);
   import dct_pkg::*;

   lex_mode_type         mode_ff, mode_in;
   logic [POS_WIDTH-1:0] line_ff, line_in, col_ff, col_in;
   logic [POS_WIDTH-1:0] sline_ff, sline_in, scol_ff, scol_in, plen_ff, plen_in;
   logic                 star_ff, star_in, exp_ff, exp_in, sign_ff, sign_in;
   logic [1:0]           dots_ff, dots_in;
   logic                 expdig_ff, expdig_in, dotexp_ff, dotexp_in;

   // event slots in emission order: mode flush, fresh punctuator,
   // end-of-source flush, end token
   token_type [3:0] slot;
   logic [3:0]      slot_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         line_ff   <= POS_WIDTH'(1);
         col_ff    <= POS_WIDTH'(1);
         sline_ff  <= '0;
         scol_ff   <= '0;
         plen_ff   <= '0;
         star_ff   <= 1'b0;
         exp_ff    <= 1'b0;
         sign_ff   <= 1'b0;
         dots_ff   <= '0;
         expdig_ff <= 1'b0;
         dotexp_ff <= 1'b0;
      end else if (req_accept) begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         sline_ff  <= sline_in;
         scol_ff   <= scol_in;
         plen_ff   <= plen_in;
         star_ff   <= star_in;
         exp_ff    <= exp_in;
         sign_ff   <= sign_in;
         dots_ff   <= dots_in;
         expdig_ff <= expdig_in;
         dotexp_ff <= dotexp_in;
      end
   end

   always_comb begin : p_next
      logic b_digit, b_dot, b_nl, do_fresh, bad_now, bad_new;
      b_digit   = is_digit(char_code);
      b_dot     = (char_code == CHAR_DOT);
      b_nl      = (char_code == CHAR_NEWLINE);
      do_fresh  = 1'b0;
      bad_new   = 1'b0;
      mode_in   = mode_ff;
      sline_in  = sline_ff;
      scol_in   = scol_ff;
      plen_in   = plen_ff;
      star_in   = star_ff;
      exp_in    = exp_ff;
      sign_in   = sign_ff;
      dots_in   = dots_ff;
      expdig_in = expdig_ff;
      dotexp_in = dotexp_ff;
      slot      = '0;
      slot_vld  = '0;
      bad_now   = (dots_ff >= 2'd2) || (exp_ff && (!expdig_ff || dotexp_ff));

      unique case (mode_ff)
         MODE_IDENT: begin
            if (is_ident_char(char_code)) begin
               plen_in = sat_inc(plen_ff);
            end else begin
               slot[0]     = mk_token(KIND_IDENT, 1'b0, sline_ff, scol_ff, plen_ff);
               slot_vld[0] = 1'b1;
               do_fresh    = 1'b1;
            end
         end
         MODE_NUMBER: begin
            sign_in = 1'b0;
            if (sign_ff && (char_code == CHAR_PLUS || char_code == CHAR_MINUS)) begin
               plen_in = sat_inc(plen_ff);
            end else if (b_digit || b_dot) begin
               if (exp_ff) begin
                  if (b_dot) dotexp_in = 1'b1;
                  else       expdig_in = 1'b1;
               end else if (b_dot && dots_ff < 2'd2) begin
                  dots_in = dots_ff + 2'd1;
               end
               plen_in = sat_inc(plen_ff);
            end else if ((char_code == CHAR_LOWER_E || char_code == CHAR_UPPER_E)
                         && !exp_ff) begin
               exp_in  = 1'b1;
               sign_in = 1'b1;
               plen_in = sat_inc(plen_ff);
            end else begin
               slot[0]     = mk_token(KIND_NUMBER, bad_now, sline_ff, scol_ff, plen_ff);
               slot_vld[0] = 1'b1;
               do_fresh    = 1'b1;
            end
         end
         MODE_SLASH: begin
            if (char_code == CHAR_SLASH) begin
               mode_in = MODE_LINE;
            end else if (char_code == CHAR_STAR) begin
               mode_in = MODE_BLOCK;
               star_in = 1'b0;
            end else begin
               slot[0]     = mk_token(KIND_SLASH, 1'b0, sline_ff, scol_ff, POS_WIDTH'(1));
               slot_vld[0] = 1'b1;
               do_fresh    = 1'b1;
            end
         end
         MODE_DOT: begin
            if (b_digit) begin
               exp_in    = 1'b0;
               sign_in   = 1'b0;
               expdig_in = 1'b0;
               dotexp_in = 1'b0;
               dots_in   = 2'd1;
               plen_in   = POS_WIDTH'(2);
               mode_in   = MODE_NUMBER;
            end else begin
               slot[0]     = mk_token(KIND_ERROR, 1'b0, sline_ff, scol_ff, POS_WIDTH'(1));
               slot_vld[0] = 1'b1;
               do_fresh    = 1'b1;
            end
         end
         MODE_LINE: begin
            if (b_nl) mode_in = MODE_NORMAL;
         end
         MODE_BLOCK: begin
            if (star_ff && char_code == CHAR_SLASH) begin
               star_in = 1'b0;
               mode_in = MODE_NORMAL;
            end else if (end_of_source) begin
               // unterminated comment: lex the final byte as ordinary input
               star_in  = 1'b0;
               do_fresh = 1'b1;
            end else begin
               star_in = (char_code == CHAR_STAR);
            end
         end
         default: do_fresh = 1'b1;
      endcase

      if (do_fresh) begin
         mode_in = MODE_NORMAL;
         if (is_space(char_code)) begin
            mode_in = MODE_NORMAL;
         end else if (is_alpha(char_code) || char_code == CHAR_UNDER || b_digit
                      || b_dot || char_code == CHAR_SLASH) begin
            sline_in = line_ff;
            scol_in  = col_ff;
            plen_in  = POS_WIDTH'(1);
            if (b_digit) begin
               exp_in    = 1'b0;
               sign_in   = 1'b0;
               dots_in   = '0;
               expdig_in = 1'b0;
               dotexp_in = 1'b0;
               mode_in   = MODE_NUMBER;
            end else if (b_dot) begin
               mode_in = MODE_DOT;
            end else if (char_code == CHAR_SLASH) begin
               mode_in = MODE_SLASH;
            end else begin
               mode_in = MODE_IDENT;
            end
         end else begin
            slot[1]     = mk_token(punct_kind(char_code), 1'b0, line_ff, col_ff,
                                   POS_WIDTH'(1));
            slot_vld[1] = 1'b1;
         end
      end

      if (b_nl) begin
         line_in = sat_inc(line_ff);
         col_in  = POS_WIDTH'(1);
      end else begin
         line_in = line_ff;
         col_in  = sat_inc(col_ff);
      end

      if (end_of_source) begin
         bad_new = (dots_in >= 2'd2) || (exp_in && (!expdig_in || dotexp_in));
         slot_vld[2] = 1'b1;
         unique case (mode_in)
            MODE_IDENT:  slot[2] = mk_token(KIND_IDENT, 1'b0, sline_in, scol_in, plen_in);
            MODE_NUMBER: slot[2] = mk_token(KIND_NUMBER, bad_new, sline_in, scol_in, plen_in);
            MODE_SLASH:  slot[2] = mk_token(KIND_SLASH, 1'b0, sline_in, scol_in,
                                            POS_WIDTH'(1));
            MODE_DOT:    slot[2] = mk_token(KIND_ERROR, 1'b0, sline_in, scol_in,
                                            POS_WIDTH'(1));
            default:     slot_vld[2] = 1'b0;
         endcase
         slot[3]     = mk_token(KIND_END, 1'b0, line_in, col_in, '0);
         slot_vld[3] = 1'b1;
         // return to the reset state for the next source
         mode_in   = MODE_NORMAL;
         line_in   = POS_WIDTH'(1);
         col_in    = POS_WIDTH'(1);
         sline_in  = '0;
         scol_in   = '0;
         plen_in   = '0;
         star_in   = 1'b0;
         exp_in    = 1'b0;
         sign_in   = 1'b0;
         dots_in   = '0;
         expdig_in = 1'b0;
         dotexp_in = 1'b0;
      end
   end

   // pack the valid slots in order; at most three are ever valid together
   always_comb begin : p_pack
      logic [2:0] idx;
      idx      = '0;
      push.tok = '0;
      for (int i = 0; i < 4; i++) begin
         if (slot_vld[i] && idx < 3'(MAX_RESULTS)) begin
            push.tok[idx[1:0]] = slot[i];
            idx                = idx + 3'd1;
         end
      end
      if (idx != 3'd0) push.tok[idx[1:0] - 2'd1].last = 1'b1;
      push.count = req_accept ? idx[1:0] : 2'd0;
   end

   `DCT_ASSERT_IMPLY(a_last_yields_token, clock, reset, req_accept && end_of_source, push.count != 2'd0)
   `DCT_ASSERT_NEXT(a_reset_after_last, clock, reset, req_accept && end_of_source, mode_ff == MODE_NORMAL && line_ff == POS_WIDTH'(1))

endmodule

@@ hdl/dct_token_fifo.sv @@
// ----------------------------------------------------------------------------
// dct_token_fifo
// Result buffer: takes up to three tokens a cycle, delivers one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
`include "dsl_char_tokenizer_defines.svh"

module dct_token_fifo (
   input  logic               clock,
   input  logic               reset,
   input  dct_pkg::push_type  push,
   output logic               room,
   output logic               out_valid,
   input  logic               out_ready,
   output dct_pkg::token_type out_tok
);
   import dct_pkg::*;

   token_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [FIFO_DEPTH-1:0]   wr_en;
   logic [FIFO_PTR_W-1:0]   wr_off [FIFO_DEPTH];
   logic                    pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_tok   = mem_ff[rd_ptr_ff];
   assign room      = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));

   // each entry checks whether it falls within this cycle's write window
   always_comb begin
      for (int j = 0; j < FIFO_DEPTH; j++) begin
         wr_off[j] = FIFO_PTR_W'(j) - wr_ptr_ff;
         wr_en[j]  = (wr_off[j] < FIFO_PTR_W'(push.count));
      end
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < FIFO_DEPTH; j++) begin
         if (wr_en[j]) mem_ff[j] <= push.tok[wr_off[j][1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `DCT_ASSERT_IMPLY(a_no_overflow, clock, reset, 1'b1, count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
   `DCT_ASSERT_IMPLY(a_push_has_room, clock, reset, push.count != 2'd0, room)

endmodule

@@ hdl/dsl_char_tokenizer.sv @@
// ----------------------------------------------------------------------------
// dsl_char_tokenizer
// Streaming tokenizer: one source byte per request, tokens out one at a time.
// ----------------------------------------------------------------------------
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid/ready, char_code, end_of_src  | in
//   rsp     | rsp_valid/ready, token_* , last_of_run  | out
//
// One byte is taken every cycle while req_ready is high; the lexer state
// updates at the accepting edge and the tokens it causes (zero to three)
// are written at that edge into an eight-entry result buffer. It drains
// one token per cycle while rsp_ready is high; req_ready drops only while
// fewer than three entries are free, so long multi-token runs stall.
// Synchronous reset returns line and column to 1 and the buffer to empty;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module dsl_char_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_token_kind,
   output logic        rsp_number_malformed,
   output logic [15:0] rsp_token_line,
   output logic [15:0] rsp_token_column,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);
   import dct_pkg::*;

   push_type  push;
   token_type head;
   logic      req_accept;

   // a request is taken whenever the buffer can absorb a worst-case burst
   assign req_accept = req_valid && req_ready;

   dct_lex_core u_core (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .char_code     (req_char_code),
      .end_of_source (req_end_of_source),
      .push          (push)
   );

   dct_token_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_tok   (head)
   );

   // drive the result fields straight from the buffer head
   assign rsp_token_kind       = head.kind;
   assign rsp_number_malformed = head.malformed;
   assign rsp_token_line       = head.line[15:0];
   assign rsp_token_column     = head.column[15:0];
   assign rsp_token_length     = head.length[15:0];
   assign rsp_last_of_run      = head.last;

endmodule
